@@ rtl/vpcs_pkg.sv @@
package vpcs_pkg;

  localparam logic [1:0] ACT_LOAD_PART = 2'd0;
  localparam logic [1:0] ACT_LOAD_LINK = 2'd1;
  localparam logic [1:0] ACT_STEP      = 2'd2;
  localparam logic [1:0] ACT_NOP       = 2'd3;

  localparam logic [3:0] REG_GRAVITY_X   = 4'd0;
  localparam logic [3:0] REG_GRAVITY_Y   = 4'd1;
  localparam logic [3:0] REG_TIME_STEP   = 4'd2;
  localparam logic [3:0] REG_SUBSTEPS    = 4'd3;
  localparam logic [3:0] REG_AREA_WIDTH  = 4'd4;
  localparam logic [3:0] REG_AREA_HEIGHT = 4'd5;
  localparam logic [3:0] REG_PART_COUNT  = 4'd6;
  localparam logic [3:0] REG_LINK_COUNT  = 4'd7;

  localparam int RESULT_CAP = 16;

  typedef struct packed {
    logic load_part;
    logic load_link;
    logic grav0;
    logic grav1;
    logic grav2;
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic j_inc;
    logic k_clr;
    logic k_inc;
    logic int_wr;
    logic cl_wr;
    logic pa_rd;
    logic pb_rd;
    logic pa_cap;
    logic pb_cap;
    logic diff_en;
    logic sq_en;
    logic sqrt_start;
    logic len_en;
    logic dlen_en;
    logic div_start;
    logic div_y;
    logic rx_cap;
    logic ry_cap;
    logic corr_en;
    logic wr_a;
    logic wr_b;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic m_zero;
    logic part_last;
    logic link_last;
    logic sub_done;
    logic link_skip;
    logic len_zero;
    logic sqrt_done;
    logic div_done;
    logic emit_last;
  } status_t;

  function automatic logic [31:0] sat32(input logic [48:0] v);
    logic [31:0] r;
    if (!v[48] && (|v[47:31])) r = 32'h7FFF_FFFF;
    else if (v[48] && !(&v[47:31])) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ rtl/vpcs_sqrt.sv @@
module vpcs_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, radicand};
      res  <= 64'd0;
      bitv <= 64'h4000_0000_0000_0000;
      cnt  <= 5'd31;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt - 5'd1;
    end
  end

endmodule

@@ rtl/vpcs_div.sv @@
module vpcs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [60:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic [30:0] quot
);

  logic [32:0] rem;
  logic [60:0] dq;
  logic [32:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] trial;
  logic        ge;

  assign trial = {rem, dq[60]};
  assign ge    = trial >= {1'b0, dvs};
  assign quot  = dq[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 33'd0;
      dq  <= dividend;
      dvs <= divisor;
      cnt <= 6'd60;
    end else if (busy) begin
      if (ge) rem <= 33'(trial - {1'b0, dvs});
      else rem <= trial[32:0];
      dq  <= {dq[59:0], ge};
      cnt <= cnt - 6'd1;
    end
  end

endmodule

@@ rtl/vpcs_dp.sv @@
module vpcs_dp #(
  parameter int MAX_PARTICLES = 16,
  parameter int MAX_LINKS     = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vpcs_pkg::cmd_t       cmd,
  output vpcs_pkg::status_t    st,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [4:0]           slot,
  input  logic [31:0]          pos_x,
  input  logic [31:0]          pos_y,
  input  logic [31:0]          prev_x,
  input  logic [31:0]          prev_y,
  input  logic [3:0]           first_end,
  input  logic [3:0]           second_end,
  input  logic [30:0]          rest_length,
  output logic [3:0]           particle_index,
  output logic [31:0]          out_x,
  output logic [31:0]          out_y,
  output logic                 last
);

  localparam int PW  = $clog2(MAX_PARTICLES);
  localparam int LW  = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int NCW = $clog2(MAX_PARTICLES + 1);
  localparam int LCW = $clog2(MAX_LINKS + 1);

  logic [31:0] gravity_x;
  logic [31:0] gravity_y;
  logic [20:0] time_step;
  logic [4:0]  substeps;
  logic [14:0] area_width;
  logic [14:0] area_height;
  logic [4:0]  particle_count;
  logic [5:0]  constraint_count;

  logic [63:0] pos_mem  [MAX_PARTICLES];
  logic [63:0] prev_mem [MAX_PARTICLES];
  logic [38:0] link_mem [MAX_LINKS];

  logic [PW-1:0] pi;
  logic [LW-1:0] lj;
  logic [4:0]    k;
  logic [NCW-1:0] n;
  logic [LCW-1:0] m;
  logic [4:0]    emit;

  logic [PW-1:0] rd_addr;
  logic [63:0]   rd_pos;
  logic [63:0]   rd_prev;
  logic [38:0]   lrd;
  logic [3:0]    la;
  logic [3:0]    lb;
  logic [30:0]   lrest;

  logic [PW-1:0] wr_addr;
  logic          pos_we;
  logic          prev_we;
  logic [63:0]   pos_wd;
  logic [63:0]   prev_wd;

  logic [25:0] dt2;
  logic [30:0] dt3;
  logic [46:0] gxr;
  logic [46:0] gyr;
  logic signed [63:0] gprod_x;
  logic signed [63:0] gprod_y;

  logic [31:0] pax, pay, pbx, pby;
  logic [32:0] magx, magy;
  logic        negx, negy, shf;
  logic [30:0] ux, uy;
  logic [61:0] sqx, sqy;
  logic [32:0] len;
  logic [33:0] dlen;
  logic [31:0] rxr, ryr;
  logic [36:0] cxr, cyr;
  logic signed [65:0] prodx;
  logic signed [65:0] prody;

  logic [32:0] dx, dy, adx, ady;
  logic        sq_done, dv_done;
  logic [31:0] root;
  logic [30:0] quot;
  logic [31:0] qs;

  logic [48:0] ix, iy, ax, ay, bx, by;
  logic [31:0] hx, hy, cx, cy;
  logic [PW:0] pi_plus;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_x        <= 32'd0;
      gravity_y        <= 32'd642253;
      time_step        <= 21'd13107;
      substeps         <= 5'd4;
      area_width       <= 15'd600;
      area_height      <= 15'd600;
      particle_count   <= 5'd0;
      constraint_count <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        vpcs_pkg::REG_GRAVITY_X:   gravity_x        <= cfg_data;
        vpcs_pkg::REG_GRAVITY_Y:   gravity_y        <= cfg_data;
        vpcs_pkg::REG_TIME_STEP:   time_step        <= cfg_data[20:0];
        vpcs_pkg::REG_SUBSTEPS:    substeps         <= cfg_data[4:0];
        vpcs_pkg::REG_AREA_WIDTH:  area_width       <= cfg_data[14:0];
        vpcs_pkg::REG_AREA_HEIGHT: area_height      <= cfg_data[14:0];
        vpcs_pkg::REG_PART_COUNT:  particle_count   <= cfg_data[4:0];
        vpcs_pkg::REG_LINK_COUNT:  constraint_count <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign n = (32'(particle_count) > MAX_PARTICLES) ? NCW'(MAX_PARTICLES)
                                                   : NCW'(particle_count);
  assign m = (32'(constraint_count) > MAX_LINKS) ? LCW'(MAX_LINKS)
                                                 : LCW'(constraint_count);
  assign emit = (32'(n) > vpcs_pkg::RESULT_CAP) ? 5'(vpcs_pkg::RESULT_CAP) : 5'(n);

  always_ff @(posedge clk) begin
    if (rst) begin
      pi <= '0;
      lj <= '0;
      k  <= 5'd0;
    end else begin
      if (cmd.i_clr) pi <= '0;
      else if (cmd.i_inc) pi <= pi + 1'b1;
      if (cmd.j_clr) lj <= '0;
      else if (cmd.j_inc) lj <= lj + 1'b1;
      if (cmd.k_clr) k <= 5'd0;
      else if (cmd.k_inc) k <= k + 5'd1;
    end
  end

  assign pi_plus = {1'b0, pi} + 1'b1;
  assign la    = lrd[3:0];
  assign lb    = lrd[7:4];
  assign lrest = lrd[38:8];

  assign st.n_zero    = (n == '0);
  assign st.m_zero    = (m == '0);
  assign st.part_last = (32'(pi_plus) == 32'(n));
  assign st.link_last = (32'(lj) + 32'd1 == 32'(m));
  assign st.sub_done  = (k == substeps);
  assign st.link_skip = (32'(la) >= 32'(n)) || (32'(lb) >= 32'(n));
  assign st.len_zero  = (len == 33'd0);
  assign st.sqrt_done = sq_done;
  assign st.div_done  = dv_done;
  assign st.emit_last = (32'(pi_plus) == 32'(emit));

  always_comb begin
    if (cmd.pa_rd) rd_addr = PW'(la);
    else if (cmd.pb_rd) rd_addr = PW'(lb);
    else rd_addr = pi;
  end

  always_ff @(posedge clk) begin
    rd_pos  <= pos_mem[rd_addr];
    rd_prev <= prev_mem[rd_addr];
    lrd     <= link_mem[lj];
  end

  assign ix = {{17{rd_pos[31]}}, rd_pos[31:0]}
            + ({{17{rd_pos[31]}}, rd_pos[31:0]} - {{17{rd_prev[31]}}, rd_prev[31:0]})
            + {{2{gxr[46]}}, gxr};
  assign iy = {{17{rd_pos[63]}}, rd_pos[63:32]}
            + ({{17{rd_pos[63]}}, rd_pos[63:32]} - {{17{rd_prev[63]}}, rd_prev[63:32]})
            + {{2{gyr[46]}}, gyr};

  assign hx = {1'b0, area_width, 16'd0};
  assign hy = {1'b0, area_height, 16'd0};
  assign cx = rd_pos[31] ? 32'd0 : ((rd_pos[31:0] > hx) ? hx : rd_pos[31:0]);
  assign cy = rd_pos[63] ? 32'd0 : ((rd_pos[63:32] > hy) ? hy : rd_pos[63:32]);

  assign ax = {{17{pax[31]}}, pax} + {{12{cxr[36]}}, cxr};
  assign ay = {{17{pay[31]}}, pay} + {{12{cyr[36]}}, cyr};
  assign bx = {{17{pbx[31]}}, pbx} - {{12{cxr[36]}}, cxr};
  assign by = {{17{pby[31]}}, pby} - {{12{cyr[36]}}, cyr};

  always_comb begin
    wr_addr = pi;
    pos_we  = 1'b0;
    prev_we = 1'b0;
    pos_wd  = {vpcs_pkg::sat32(iy), vpcs_pkg::sat32(ix)};
    prev_wd = rd_pos;
    if (cmd.load_part) begin
      wr_addr = PW'(slot);
      pos_we  = (32'(slot) < MAX_PARTICLES);
      prev_we = (32'(slot) < MAX_PARTICLES);
      pos_wd  = {pos_y, pos_x};
      prev_wd = {prev_y, prev_x};
    end else if (cmd.int_wr) begin
      pos_we  = 1'b1;
      prev_we = 1'b1;
    end else if (cmd.cl_wr) begin
      pos_we = 1'b1;
      pos_wd = {cy, cx};
    end else if (cmd.wr_a) begin
      wr_addr = PW'(la);
      pos_we  = 1'b1;
      pos_wd  = {vpcs_pkg::sat32(ay), vpcs_pkg::sat32(ax)};
    end else if (cmd.wr_b) begin
      wr_addr = PW'(lb);
      pos_we  = 1'b1;
      pos_wd  = {vpcs_pkg::sat32(by), vpcs_pkg::sat32(bx)};
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[wr_addr] <= pos_wd;
    if (prev_we) prev_mem[wr_addr] <= prev_wd;
    if (cmd.load_link && (32'(slot) < MAX_LINKS)) begin
      link_mem[LW'(slot)] <= {rest_length, second_end, first_end};
    end
  end

  assign gprod_x = $signed(gravity_x) * $signed({1'b0, dt3});
  assign gprod_y = $signed(gravity_y) * $signed({1'b0, dt3});

  always_ff @(posedge clk) begin
    if (cmd.grav0) dt2 <= 26'((42'(time_step) * 42'(time_step)) >> 16);
    if (cmd.grav1) dt3 <= 31'((47'(dt2) * 47'(time_step)) >> 16);
    if (cmd.grav2) begin
      gxr <= gprod_x[62:16];
      gyr <= gprod_y[62:16];
    end
  end

  assign dx  = {pbx[31], pbx} - {pax[31], pax};
  assign dy  = {pby[31], pby} - {pay[31], pay};
  assign adx = dx[32] ? (33'd0 - dx) : dx;
  assign ady = dy[32] ? (33'd0 - dy) : dy;

  assign qs    = {1'b0, quot};
  assign prodx = $signed(dlen) * $signed(rxr);
  assign prody = $signed(dlen) * $signed(ryr);

  always_ff @(posedge clk) begin
    if (cmd.pa_cap) begin
      pax <= rd_pos[31:0];
      pay <= rd_pos[63:32];
    end
    if (cmd.pb_cap) begin
      pbx <= rd_pos[31:0];
      pby <= rd_pos[63:32];
    end
    if (cmd.diff_en) begin
      magx <= adx;
      magy <= ady;
      negx <= dx[32];
      negy <= dy[32];
      if ((|adx[32:31]) || (|ady[32:31])) begin
        shf <= 1'b1;
        ux  <= adx[31:1];
        uy  <= ady[31:1];
      end else begin
        shf <= 1'b0;
        ux  <= adx[30:0];
        uy  <= ady[30:0];
      end
    end
    if (cmd.sq_en) begin
      sqx <= 62'(ux) * 62'(ux);
      sqy <= 62'(uy) * 62'(uy);
    end
    if (cmd.len_en) len <= {1'b0, root} << shf;
    if (cmd.dlen_en) dlen <= {1'b0, len} - {3'd0, lrest};
    if (cmd.rx_cap) rxr <= negx ? (32'd0 - qs) : qs;
    if (cmd.ry_cap) ryr <= negy ? (32'd0 - qs) : qs;
    if (cmd.corr_en) begin
      cxr <= prodx[65:29];
      cyr <= prody[65:29];
    end
    if (cmd.out_ld) begin
      particle_index <= 4'(pi);
      out_x          <= rd_pos[31:0];
      out_y          <= rd_pos[63:32];
      last           <= st.emit_last;
    end
  end

  vpcs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (63'(sqx) + 63'(sqy)),
    .done     (sq_done),
    .root     (root)
  );

  vpcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_y ? {magy, 28'd0} : {magx, 28'd0}),
    .divisor  (len),
    .done     (dv_done),
    .quot     (quot)
  );

endmodule

@@ rtl/vpcs_ctrl.sv @@
module vpcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          action,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  vpcs_pkg::status_t   st,
  output vpcs_pkg::cmd_t      cmd
);

  typedef enum logic [28:0] {
    S_IDLE    = 29'd1 << 0,
    S_GRAV0   = 29'd1 << 1,
    S_GRAV1   = 29'd1 << 2,
    S_GRAV2   = 29'd1 << 3,
    S_INT_RD  = 29'd1 << 4,
    S_INT_WR  = 29'd1 << 5,
    S_SUB_CHK = 29'd1 << 6,
    S_CL_RD   = 29'd1 << 7,
    S_CL_WR   = 29'd1 << 8,
    S_LK_RD   = 29'd1 << 9,
    S_LK_CHK  = 29'd1 << 10,
    S_PA_RD   = 29'd1 << 11,
    S_PB_RD   = 29'd1 << 12,
    S_PB_CAP  = 29'd1 << 13,
    S_DIFF    = 29'd1 << 14,
    S_SQR     = 29'd1 << 15,
    S_SQ_GO   = 29'd1 << 16,
    S_SQ_WAIT = 29'd1 << 17,
    S_LEN_CHK = 29'd1 << 18,
    S_DIVX    = 29'd1 << 19,
    S_DIVY    = 29'd1 << 20,
    S_CORR    = 29'd1 << 21,
    S_WR_A    = 29'd1 << 22,
    S_WR_B    = 29'd1 << 23,
    S_LK_NEXT = 29'd1 << 24,
    S_SUB_END = 29'd1 << 25,
    S_EM_RD   = 29'd1 << 26,
    S_EM_LD   = 29'd1 << 27,
    S_EM_WAIT = 29'd1 << 28
  } state_t;

  state_t state, state_next;
  logic   in_acc;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_EM_WAIT);
  assign in_acc    = in_valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load_part = in_acc && (action == vpcs_pkg::ACT_LOAD_PART);
        cmd.load_link = in_acc && (action == vpcs_pkg::ACT_LOAD_LINK);
        if (in_acc && action == vpcs_pkg::ACT_STEP) state_next = S_GRAV0;
      end
      S_GRAV0: begin
        cmd.grav0  = 1'b1;
        state_next = S_GRAV1;
      end
      S_GRAV1: begin
        cmd.grav1  = 1'b1;
        state_next = S_GRAV2;
      end
      S_GRAV2: begin
        cmd.grav2  = 1'b1;
        cmd.i_clr  = 1'b1;
        cmd.k_clr  = 1'b1;
        state_next = st.n_zero ? S_IDLE : S_INT_RD;
      end
      S_INT_RD: state_next = S_INT_WR;
      S_INT_WR: begin
        cmd.int_wr = 1'b1;
        if (st.part_last) begin
          state_next = S_SUB_CHK;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_INT_RD;
        end
      end
      S_SUB_CHK: begin
        cmd.i_clr  = 1'b1;
        state_next = st.sub_done ? S_EM_RD : S_CL_RD;
      end
      S_CL_RD: state_next = S_CL_WR;
      S_CL_WR: begin
        cmd.cl_wr = 1'b1;
        if (st.part_last) begin
          cmd.j_clr  = 1'b1;
          state_next = st.m_zero ? S_SUB_END : S_LK_RD;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_CL_RD;
        end
      end
      S_LK_RD: state_next = S_LK_CHK;
      S_LK_CHK: state_next = st.link_skip ? S_LK_NEXT : S_PA_RD;
      S_PA_RD: begin
        cmd.pa_rd  = 1'b1;
        state_next = S_PB_RD;
      end
      S_PB_RD: begin
        cmd.pb_rd  = 1'b1;
        cmd.pa_cap = 1'b1;
        state_next = S_PB_CAP;
      end
      S_PB_CAP: begin
        cmd.pb_cap = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        state_next  = S_SQR;
      end
      S_SQR: begin
        cmd.sq_en  = 1'b1;
        state_next = S_SQ_GO;
      end
      S_SQ_GO: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (st.sqrt_done) begin
          cmd.len_en = 1'b1;
          state_next = S_LEN_CHK;
        end
      end
      S_LEN_CHK: begin
        cmd.dlen_en = 1'b1;
        if (st.len_zero) begin
          state_next = S_LK_NEXT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVX;
        end
      end
      S_DIVX: begin
        if (st.div_done) begin
          cmd.rx_cap    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_y     = 1'b1;
          state_next    = S_DIVY;
        end
      end
      S_DIVY: begin
        if (st.div_done) begin
          cmd.ry_cap = 1'b1;
          state_next = S_CORR;
        end
      end
      S_CORR: begin
        cmd.corr_en = 1'b1;
        state_next  = S_WR_A;
      end
      S_WR_A: begin
        cmd.wr_a   = 1'b1;
        state_next = S_WR_B;
      end
      S_WR_B: begin
        cmd.wr_b   = 1'b1;
        state_next = S_LK_NEXT;
      end
      S_LK_NEXT: begin
        if (st.link_last) begin
          state_next = S_SUB_END;
        end else begin
          cmd.j_inc  = 1'b1;
          state_next = S_LK_RD;
        end
      end
      S_SUB_END: begin
        cmd.k_inc  = 1'b1;
        state_next = S_SUB_CHK;
      end
      S_EM_RD: state_next = S_EM_LD;
      S_EM_LD: begin
        cmd.out_ld = 1'b1;
        state_next = S_EM_WAIT;
      end
      S_EM_WAIT: begin
        if (!out_stall) begin
          if (st.emit_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.i_inc  = 1'b1;
            state_next = S_EM_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/verlet_particle_constraint_step_core.sv @@
// Verlet particle step with distance constraints, signed Q16.16.
// Input channel (in_valid/in_stall): action 0 loads one particle at slot,
// action 1 loads one link at slot, action 2 runs one simulation step. Loads
// return nothing. Other actions are dropped.
// Output channel (out_valid/out_stall): a step returns one item per particle
// in use (at most 16) in index order; last marks the final one.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write only
// while the block is idle.
// Sequence: a step first integrates every particle, then per substep clamps
// every particle and relaxes each active link (32 square root iterations
// and two 61-iteration divides on shared iterative units), passing over
// skipped links, then emits the results.
// One item is in work at a time; in_stall stays high until the last result
// is taken. A stalled result holds in the output register.
// Reset clears the controller and config registers to their defaults; table
// contents are undefined until loaded.
module verlet_particle_constraint_step_core #(
  parameter int MAX_PARTICLES = 16,
  parameter int MAX_LINKS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [4:0]  slot,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] prev_x,
  input  logic [31:0] prev_y,
  input  logic [3:0]  first_end,
  input  logic [3:0]  second_end,
  input  logic [30:0] rest_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  particle_index,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  vpcs_pkg::cmd_t    cmd;
  vpcs_pkg::status_t st;

  assign cfg_ready = 1'b1;

  vpcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  vpcs_dp #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .MAX_LINKS     (MAX_LINKS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .slot           (slot),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .prev_x         (prev_x),
    .prev_y         (prev_y),
    .first_end      (first_end),
    .second_end     (second_end),
    .rest_length    (rest_length),
    .particle_index (particle_index),
    .out_x          (out_x),
    .out_y          (out_y),
    .last           (last)
  );

  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && action == vpcs_pkg::ACT_STEP) |=> in_stall)
    else $error("step item did not occupy the block");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !out_valid)
    else $error("result after last of step");

  a_out_only_busy: assert property (@(posedge clk) disable iff (rst)
    (!in_stall) |-> !out_valid)
    else $error("result shown while idle");

endmodule
